FILE: src/sfcc_pkg.sv
// Package for the sensor frame CRC check core: frame types, status codes,
// CRC-8 and scaling constants. No dependencies.
package sfcc_pkg;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;

    typedef enum logic [2:0] {
        POS_TEMP_HI  = 3'd0,
        POS_TEMP_LO  = 3'd1,
        POS_TEMP_CRC = 3'd2,
        POS_HUM_HI   = 3'd3,
        POS_HUM_LO   = 3'd4,
        POS_HUM_CRC  = 3'd5
    } t_pos;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TEMP_BAD = 2'd1,
        ST_HUM_BAD  = 2'd2
    } t_status;

    typedef struct packed {
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
        t_status     status;
    } t_frame;

    function automatic logic [7:0] crc8_feed(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: src/sfcc_if.sv
// Handshake interfaces for the sensor frame CRC check core: byte input and
// result output. No dependencies.
interface sfcc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface sfcc_res_if;
    logic               valid;
    logic               ready;
    logic [15:0]        temp_raw;
    logic [15:0]        hum_raw;
    logic signed [14:0] temp_centideg;
    logic [13:0]        hum_centipct;
    logic [1:0]         frame_status;
    modport source (output valid, output temp_raw, output hum_raw, output temp_centideg,
                    output hum_centipct, output frame_status, input ready);
    modport sink (input valid, input temp_raw, input hum_raw, input temp_centideg,
                  input hum_centipct, input frame_status, output ready);
endinterface

FILE: src/sensor_frame_crc_check_core.sv
// Top level of the sensor frame CRC check core: frame assembler followed by
// the conversion pipeline. Depends on sfcc_pkg, sfcc_if, sfcc_frame, sfcc_conv.
//
//  channel   dir  handshake            payload
//  i_byte    in   valid/ready          data_byte
//  o_res     out  valid/ready          temp_raw, hum_raw, temp_centideg,
//                                      hum_centipct, frame_status
//
// One byte accepted per cycle while o_res is not stalled; every sixth byte
// yields one item, which passes through the frame register, the product
// register and the result register after its last byte.
// Synchronous active-low reset returns to the first byte of a frame.
// A stalled output fills the stages behind it, then holds i_byte.ready low.
module sensor_frame_crc_check_core import sfcc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfcc_byte_if.sink  i_byte,
    sfcc_res_if.source o_res
);

    logic    frm_valid, frm_ready;
    t_frame  frm;
    t_status status;

    sfcc_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_byte.valid),
        .o_ready     (i_byte.ready),
        .i_data_byte (i_byte.data_byte),
        .o_valid     (frm_valid),
        .i_ready     (frm_ready),
        .o_frame     (frm)
    );

    sfcc_conv u_conv (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (frm_valid),
        .o_ready         (frm_ready),
        .i_frame         (frm),
        .o_valid         (o_res.valid),
        .i_ready         (o_res.ready),
        .o_temp_raw      (o_res.temp_raw),
        .o_hum_raw       (o_res.hum_raw),
        .o_temp_centideg (o_res.temp_centideg),
        .o_hum_centipct  (o_res.hum_centipct),
        .o_status        (status)
    );

    assign o_res.frame_status = status;

endmodule

FILE: src/sfcc_frame.sv
// Frame assembler: tracks byte position, runs the CRC-8 and registers one
// raw frame with its status per six bytes. Depends on sfcc_pkg.
module sfcc_frame import sfcc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output t_frame     o_frame
);

    t_pos        r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_temp, n_temp;
    logic [15:0] r_hum, n_hum;
    logic        r_bad, n_bad;
    logic        r_v, n_v;
    t_frame      r_frame, n_frame;
    logic        acc;
    logic        load_out;

    assign o_ready  = !r_v || i_ready;
    assign acc      = i_valid && o_ready;
    assign load_out = acc && (r_pos == POS_HUM_CRC);
    assign o_valid  = r_v;
    assign o_frame  = r_frame;

    always_comb begin
        n_pos   = r_pos;
        n_crc   = r_crc;
        n_temp  = r_temp;
        n_hum   = r_hum;
        n_bad   = r_bad;
        n_frame = r_frame;
        n_v     = r_v && !i_ready;
        if (acc) begin
            case (r_pos)
                POS_TEMP_LO: begin
                    n_temp = {r_temp[15:8], i_data_byte};
                    n_crc  = crc8_feed(r_crc, i_data_byte);
                    n_pos  = POS_TEMP_CRC;
                end
                POS_TEMP_CRC: begin
                    n_bad = (r_crc != i_data_byte);
                    n_pos = POS_HUM_HI;
                end
                POS_HUM_HI: begin
                    n_hum = {i_data_byte, 8'h00};
                    n_crc = crc8_feed(CRC_INIT, i_data_byte);
                    n_pos = POS_HUM_LO;
                end
                POS_HUM_LO: begin
                    n_hum = {r_hum[15:8], i_data_byte};
                    n_crc = crc8_feed(r_crc, i_data_byte);
                    n_pos = POS_HUM_CRC;
                end
                POS_HUM_CRC: begin
                    n_frame.temp_raw = r_temp;
                    n_frame.hum_raw  = r_hum;
                    if (r_bad) begin
                        n_frame.status = ST_TEMP_BAD;
                    end else if (r_crc != i_data_byte) begin
                        n_frame.status = ST_HUM_BAD;
                    end else begin
                        n_frame.status = ST_OK;
                    end
                    n_v   = 1'b1;
                    n_pos = POS_TEMP_HI;
                    n_crc = CRC_INIT;
                    n_bad = 1'b0;
                end
                default: begin
                    n_temp = {i_data_byte, 8'h00};
                    n_crc  = crc8_feed(CRC_INIT, i_data_byte);
                    n_pos  = POS_TEMP_LO;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_TEMP_HI;
            r_crc  <= CRC_INIT;
            r_temp <= 16'h0000;
            r_hum  <= 16'h0000;
            r_bad  <= 1'b0;
            r_v    <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_temp <= n_temp;
            r_hum  <= n_hum;
            r_bad  <= n_bad;
            r_v    <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
    end

    a_frame_end_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_pos == POS_TEMP_HI) && (r_crc == CRC_INIT) && !r_bad)
        else $error("frame state not restarted after last byte");

    a_frame_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> r_v)
        else $error("frame result not registered after last byte");

    a_frame_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v ##1 r_v |-> $past(load_out))
        else $error("frame result raised without a last byte");

endmodule

FILE: src/sfcc_conv.sv
// Conversion pipeline: scales the raw words to centidegrees and centipercent
// (multiply, divide by full scale, subtract temperature offset). Depends on sfcc_pkg.
module sfcc_conv import sfcc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_frame             i_frame,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_temp_raw,
    output logic [15:0]        o_hum_raw,
    output logic signed [14:0] o_temp_centideg,
    output logic [13:0]        o_hum_centipct,
    output t_status            o_status
);

    logic               r_v1, r_v2;
    logic               free2, adv1, adv2;
    t_frame             r_f1;
    logic [30:0]        r_tp;
    logic [29:0]        r_hp;
    logic [14:0]        tq;
    logic [13:0]        hq;
    logic [16:0]        tr, hr;
    logic [15:0]        r_temp_raw, r_hum_raw;
    logic signed [14:0] r_temp_c;
    logic [13:0]        r_hum_c;
    t_status            r_status;

    assign free2   = !r_v2 || i_ready;
    assign o_ready = !r_v1 || free2;
    assign adv1    = i_valid && o_ready;
    assign adv2    = r_v1 && free2;

    // floor(p / 65535): p = q*65536 + lo = q*65535 + (lo + q), remainder below 2*65535
    always_comb begin
        tr = {1'b0, r_tp[15:0]} + {2'b00, r_tp[30:16]};
        tq = r_tp[30:16] + {14'd0, (tr >= FULL_SCALE)};
        hr = {1'b0, r_hp[15:0]} + {3'b000, r_hp[29:16]};
        hq = r_hp[29:16] + {13'd0, (hr >= FULL_SCALE)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v1 <= i_valid;
            end
            if (free2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_f1 <= i_frame;
            r_tp <= 31'(i_frame.temp_raw * TEMP_SPAN);
            r_hp <= 30'(i_frame.hum_raw * HUM_SPAN);
        end
        if (adv2) begin
            r_temp_raw <= r_f1.temp_raw;
            r_hum_raw  <= r_f1.hum_raw;
            r_temp_c   <= $signed(tq - TEMP_OFFSET);
            r_hum_c    <= hq;
            r_status   <= r_f1.status;
        end
    end

    assign o_valid         = r_v2;
    assign o_temp_raw      = r_temp_raw;
    assign o_hum_raw       = r_hum_raw;
    assign o_temp_centideg = r_temp_c;
    assign o_hum_centipct  = r_hum_c;
    assign o_status        = r_status;

    a_conv_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv2 |=> r_v2)
        else $error("conversion stage lost an item");

    a_conv_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !free2 |=> r_v1 && $stable(r_tp) && $stable(r_hp))
        else $error("stalled product stage changed");

    a_conv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_hum_c <= HUM_SPAN) && (r_temp_c >= -15'sd4500) && (r_temp_c <= 15'sd13000))
        else $error("converted value out of range");

endmodule

FILE: test/tb.sv
// Testbench for sensor_frame_crc_check_core: drives six-byte sensor frames with good and
// corrupted CRC-8 bytes and checks every reading against a frame decoder kept in step.
// Depends on sfcc_pkg, sfcc_if and the core itself.
module tb;
    import sfcc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 12;

    typedef struct {
        logic [15:0]        temp_raw;
        logic [15:0]        hum_raw;
        logic signed [14:0] temp_centideg;
        logic [13:0]        hum_centipct;
        logic [1:0]         frame_status;
    } t_reading;

    class frame_scoreboard;
        t_pos        pos;
        logic [7:0]  crc;
        logic [15:0] temp_word;
        logic [15:0] hum_word;
        bit          temp_bad;
        t_reading    expected_readings[$];
        int          mismatches;

        function new();
            pos        = POS_TEMP_HI;
            crc        = CRC_INIT;
            temp_word  = '0;
            hum_word   = '0;
            temp_bad   = 1'b0;
            mismatches = 0;
        endfunction

        static function logic [7:0] crc_over(logic [7:0] acc, logic [7:0] b);
            logic [7:0] r;
            r = acc ^ b;
            repeat (8) begin
                r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
            end
            return r;
        endfunction

        function void absorb_byte(logic [7:0] b);
            t_reading r;
            int       tq;
            int       hq;
            case (pos)
                POS_TEMP_LO: begin
                    temp_word[7:0] = b;
                    crc = crc_over(crc, b);
                    pos = POS_TEMP_CRC;
                end
                POS_TEMP_CRC: begin
                    temp_bad = (crc != b);
                    pos = POS_HUM_HI;
                end
                POS_HUM_HI: begin
                    hum_word = {b, 8'h00};
                    crc = crc_over(CRC_INIT, b);
                    pos = POS_HUM_LO;
                end
                POS_HUM_LO: begin
                    hum_word[7:0] = b;
                    crc = crc_over(crc, b);
                    pos = POS_HUM_CRC;
                end
                POS_HUM_CRC: begin
                    tq = (int'(TEMP_SPAN) * int'(temp_word)) / int'(FULL_SCALE);
                    hq = (int'(HUM_SPAN) * int'(hum_word)) / int'(FULL_SCALE);
                    r.temp_raw      = temp_word;
                    r.hum_raw       = hum_word;
                    r.temp_centideg = 15'(tq - int'(TEMP_OFFSET));
                    r.hum_centipct  = 14'(hq);
                    if (temp_bad) begin
                        r.frame_status = ST_TEMP_BAD;
                    end else if (crc != b) begin
                        r.frame_status = ST_HUM_BAD;
                    end else begin
                        r.frame_status = ST_OK;
                    end
                    expected_readings.push_back(r);
                    pos      = POS_TEMP_HI;
                    crc      = CRC_INIT;
                    temp_bad = 1'b0;
                end
                default: begin
                    temp_word = {b, 8'h00};
                    crc = crc_over(CRC_INIT, b);
                    pos = POS_TEMP_LO;
                end
            endcase
        endfunction

        function void check_reading(t_reading got);
            t_reading want;
            if (expected_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected reading: temp %h hum %h status %0d",
                             got.temp_raw, got.hum_raw, got.frame_status);
                end
                return;
            end
            want = expected_readings.pop_front();
            if (got.temp_raw !== want.temp_raw || got.hum_raw !== want.hum_raw ||
                got.temp_centideg !== want.temp_centideg ||
                got.hum_centipct !== want.hum_centipct ||
                got.frame_status !== want.frame_status) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("reading mismatch: expected %h %h %0d %0d %0d, got %h %h %0d %0d %0d",
                             want.temp_raw, want.hum_raw, want.temp_centideg,
                             want.hum_centipct, want.frame_status,
                             got.temp_raw, got.hum_raw, got.temp_centideg,
                             got.hum_centipct, got.frame_status);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   quiet_cycles;

    frame_scoreboard sb = new();

    sfcc_byte_if byte_if();
    sfcc_res_if  res_if();

    sensor_frame_crc_check_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (byte_if),
        .o_res   (res_if)
    );

    always begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    initial begin
        rst_n             = 1'b0;
        byte_if.valid     = 1'b0;
        byte_if.data_byte = 8'h00;
        res_if.ready      = 1'b1;
        src_idle_pct      = 0;
        snk_idle_pct      = 0;
        quiet_cycles      = 0;
    end

    always @(posedge clk) begin
        t_reading got;
        logic     took_byte;
        logic     took_reading;
        took_byte    = rst_n && byte_if.valid && byte_if.ready;
        took_reading = rst_n && res_if.valid && res_if.ready;
        if (took_byte) begin
            sb.absorb_byte(byte_if.data_byte);
        end
        if (took_reading) begin
            got.temp_raw      = res_if.temp_raw;
            got.hum_raw       = res_if.hum_raw;
            got.temp_centideg = res_if.temp_centideg;
            got.hum_centipct  = res_if.hum_centipct;
            got.frame_status  = res_if.frame_status;
            sb.check_reading(got);
        end
        if (took_byte || took_reading) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stall the result side in bursts
    initial begin
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 99) < snk_idle_pct) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            byte_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= b;
        do @(posedge clk); while (byte_if.ready !== 1'b1);
    endtask

    task automatic send_frame(input logic [15:0] temp, input logic [15:0] hum,
                              input bit spoil_temp, input bit spoil_hum);
        logic [7:0] temp_check;
        logic [7:0] hum_crc;
        temp_check = frame_scoreboard::crc_over(frame_scoreboard::crc_over(CRC_INIT, temp[15:8]),
                                                temp[7:0]);
        hum_crc    = frame_scoreboard::crc_over(frame_scoreboard::crc_over(CRC_INIT, hum[15:8]),
                                                hum[7:0]);
        if (spoil_temp) temp_check ^= 8'($urandom_range(1, 255));
        if (spoil_hum) hum_crc ^= 8'($urandom_range(1, 255));
        send_byte(temp[15:8]);
        send_byte(temp[7:0]);
        send_byte(temp_check);
        send_byte(hum[15:8]);
        send_byte(hum[7:0]);
        send_byte(hum_crc);
    endtask

    function automatic logic [15:0] pick_word();
        logic [15:0] edges[4] = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE};
        if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 3)];
        return 16'($urandom);
    endfunction

    initial begin
        int idle_levels[3] = '{0, 10, 40};
        int kind;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0);
        send_frame(16'hFFFF, 16'h0000, 1'b1, 1'b0);
        send_frame(16'h8000, 16'h7FFF, 1'b0, 1'b1);
        send_frame(16'h5A5A, 16'hA5A5, 1'b1, 1'b1);

        for (int blk = 0; blk < 4; blk++) begin
            src_idle_pct = (blk == 3) ? 0 : idle_levels[$urandom_range(0, 2)];
            snk_idle_pct = (blk == 3) ? 0 : idle_levels[$urandom_range(0, 2)];
            repeat (50) begin
                kind = $urandom_range(0, 9);
                send_frame(pick_word(), pick_word(), kind == 0 || kind == 2,
                           kind == 1 || kind == 2);
            end
        end
        byte_if.valid <= 1'b0;

        while (sb.expected_readings.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_readings.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

FILE: sensor_frame_crc_check_core.f
src/sfcc_pkg.sv
src/sfcc_if.sv
src/sfcc_frame.sv
src/sfcc_conv.sv
src/sensor_frame_crc_check_core.sv
test/tb.sv
